FILE: rtl/mvc_pkg.sv
package mvc_pkg;

   // Fixed field widths and default sizes.
   localparam int SAMPLE_BITS     = 16;
   localparam int DELAY_DEPTH_DEF = 4096;
   localparam int VOICE_LIMIT_DEF = 8;
   localparam int OSC_W           = 18;
   localparam int OSC_SUM_W       = 20;
   localparam int D_W             = 26;
   localparam int CFG_W           = 20;
   localparam int CSR_IDX_W       = 3;
   localparam int VAL_W           = SAMPLE_BITS + 4;
   localparam int MA_W            = 40;
   localparam int MB_W            = 22;
   localparam int MP_W            = MA_W + MB_W;
   localparam int ACC_W           = 40;
   localparam int CORDIC_W        = 34;
   localparam int CORDIC_STEPS    = 20;
   localparam int CORDIC_X0       = 652032874;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LFO_STEP,
      REG_MOD_DEPTH,
      REG_WET_MIX,
      REG_VOICE_COUNT,
      REG_BASE_DELAY,
      REG_MOD_RANGE,
      REG_VOICE_SPREAD
   } reg_index_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_SEED_GO,
      ST_SEED_WAIT,
      ST_IDLE,
      ST_EPSC,
      ST_SIN,
      ST_COS,
      ST_RD,
      ST_MOD,
      ST_POS,
      ST_TAP0,
      ST_TAP1,
      ST_TAP2,
      ST_TAP3,
      ST_CUBE,
      ST_H1,
      ST_H2,
      ST_H3,
      ST_DIV_LOAD,
      ST_DIV,
      ST_OUT1,
      ST_OUT2,
      ST_OUT3,
      ST_EMIT
   } state_type;

   // Result of one phase-seed rotation.
   typedef struct packed {
      logic                    done;
      logic signed [OSC_W-1:0] cos_val;
      logic signed [OSC_W-1:0] sin_val;
   } cordic_res_type;

   // Rotation angles in 2^-32 turns.
   function automatic logic [29:0] atan_turn(input logic [4:0] k);
      logic [29:0] r;
      case (k)
         5'd0:  r = 30'd536870912;
         5'd1:  r = 30'd316933406;
         5'd2:  r = 30'd167458907;
         5'd3:  r = 30'd85004756;
         5'd4:  r = 30'd42667331;
         5'd5:  r = 30'd21354465;
         5'd6:  r = 30'd10679838;
         5'd7:  r = 30'd5340245;
         5'd8:  r = 30'd2670163;
         5'd9:  r = 30'd1335087;
         5'd10: r = 30'd667544;
         5'd11: r = 30'd333772;
         5'd12: r = 30'd166886;
         5'd13: r = 30'd83443;
         5'd14: r = 30'd41722;
         5'd15: r = 30'd20861;
         5'd16: r = 30'd10430;
         5'd17: r = 30'd5215;
         5'd18: r = 30'd2608;
         5'd19: r = 30'd1304;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

   // Quotient of one full turn by the voice count.
   function automatic logic [31:0] phase_quot(input logic [4:0] n);
      logic [31:0] r;
      case (n)
         5'd2:  r = 32'd2147483648;
         5'd3:  r = 32'd1431655765;
         5'd4:  r = 32'd1073741824;
         5'd5:  r = 32'd858993459;
         5'd6:  r = 32'd715827882;
         5'd7:  r = 32'd613566756;
         5'd8:  r = 32'd536870912;
         5'd9:  r = 32'd477218588;
         5'd10: r = 32'd429496729;
         5'd11: r = 32'd390451572;
         5'd12: r = 32'd357913941;
         5'd13: r = 32'd330382099;
         5'd14: r = 32'd306783378;
         5'd15: r = 32'd286331153;
         5'd16: r = 32'd268435456;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   // Remainder of one full turn by the voice count.
   function automatic logic [4:0] phase_rem(input logic [4:0] n);
      logic [4:0] r;
      case (n)
         5'd3, 5'd5, 5'd15: r = 5'd1;
         5'd6, 5'd7, 5'd9, 5'd11, 5'd12, 5'd14: r = 5'd4;
         5'd10: r = 5'd6;
         5'd13: r = 5'd9;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // Saturate an oscillator sum to the 18-bit range.
   function automatic logic signed [OSC_W-1:0] sat_osc(input logic signed [OSC_SUM_W-1:0] v);
      logic signed [OSC_W-1:0] r;
      if (v > OSC_SUM_W'(131071)) begin
         r = OSC_W'(131071);
      end else if (v < -OSC_SUM_W'(131072)) begin
         r = -OSC_W'(131072);
      end else begin
         r = v[OSC_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/mvc_mult.sv
module mvc_mult (
   input  logic                              clock,
   input  logic signed [mvc_pkg::MA_W-1:0]   a,
   input  logic signed [mvc_pkg::MB_W-1:0]   b,
   output logic signed [mvc_pkg::MP_W-1:0]   p
);
   import mvc_pkg::*;

   logic signed [MP_W-1:0] p_ff;

   // Shared registered multiplier.
   always_ff @(posedge clock) begin
      p_ff <= a * b;
   end

   assign p = p_ff;

endmodule

FILE: rtl/mvc_delay_ram.sv
module mvc_delay_ram #(
   parameter int DEPTH = mvc_pkg::DELAY_DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                we,
   input  logic [AW-1:0]                       waddr,
   input  logic signed [mvc_pkg::SAMPLE_BITS-1:0] wdata,
   input  logic [AW-1:0]                       raddr,
   output logic signed [mvc_pkg::SAMPLE_BITS-1:0] rdata,
   output logic                                ready
);
   import mvc_pkg::*;

   logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
   logic signed [SAMPLE_BITS-1:0] rdata_ff;
   logic [AW-1:0]                 clr_ff;
   logic                          clearing_ff;

   // Clearing pass after reset, one entry per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clearing_ff <= 1'b1;
      end else if (clearing_ff) begin
         clr_ff <= clr_ff + AW'(1);
         if (clr_ff == AW'(DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Single write port and one registered read port.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_ff] <= '0;
      end else if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
   assign ready = !clearing_ff;

endmodule

FILE: rtl/mvc_cordic.sv
module mvc_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [31:0]             turn,
   output mvc_pkg::cordic_res_type res
);
   import mvc_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff, y_ff, z_ff;
   logic signed [CORDIC_W-1:0] dx, dy, atan_v, c_full, s_full;
   logic signed [OSC_W-1:0]    c_r, s_r;
   logic [4:0]                 k_ff;
   logic [1:0]                 q_ff;
   logic                       busy_ff, done_ff;

   assign dx     = y_ff >>> k_ff;
   assign dy     = x_ff >>> k_ff;
   assign atan_v = $signed(CORDIC_W'(atan_turn(k_ff)));

   // Control of the rotation sequence.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (busy_ff) begin
            k_ff <= k_ff + 5'd1;
            if (k_ff == 5'(CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // One rotation step per cycle.
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= CORDIC_W'(CORDIC_X0);
         y_ff <= '0;
         z_ff <= $signed(CORDIC_W'(turn[29:0]));
         q_ff <= turn[31:30];
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - atan_v;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + atan_v;
         end
      end
   end

   // Round to Q2.16 and fold in the quadrant.
   always_comb begin
      c_full = (x_ff + CORDIC_W'(8192)) >>> 14;
      s_full = (y_ff + CORDIC_W'(8192)) >>> 14;
      c_r    = c_full[OSC_W-1:0];
      s_r    = s_full[OSC_W-1:0];
      res.done = done_ff;
      case (q_ff)
         2'd0: begin
            res.cos_val = c_r;
            res.sin_val = s_r;
         end
         2'd1: begin
            res.cos_val = -s_r;
            res.sin_val = c_r;
         end
         2'd2: begin
            res.cos_val = -c_r;
            res.sin_val = -s_r;
         end
         default: begin
            res.cos_val = s_r;
            res.sin_val = -c_r;
         end
      endcase
   end

endmodule

FILE: rtl/multivoice_chorus.sv
// A sample is taken only in the idle state: the block takes no new sample until it has worked
// through every active voice and emitted the last result, and emitting waits while an earlier
// result still waits on rsp_tready.
// Each voice runs seven passes through the one shared multiplier and four delay-line reads;
// the voice average is a divider retiring one bit per cycle. Reset restores the register
// defaults, seeds the oscillators and clears the delay line one entry per cycle
// (DELAY_DEPTH entries, 4096 by default); no sample is taken until it ends.
module multivoice_chorus #(
   parameter int DELAY_DEPTH = mvc_pkg::DELAY_DEPTH_DEF,
   parameter int VOICE_LIMIT = mvc_pkg::VOICE_LIMIT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mvc_pkg::SAMPLE_BITS-1:0]   req_tdata,   // [15:0] sample_in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mvc_pkg::SAMPLE_BITS-1:0]   rsp_tdata,   // [15:0] sample_out
   input  logic                              csr_we,
   input  logic [mvc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mvc_pkg::CFG_W-1:0]         csr_wdata
);
   import mvc_pkg::*;

   localparam int AW    = $clog2(DELAY_DEPTH);
   localparam int VIW   = $clog2(VOICE_LIMIT);
   localparam int NV_W  = $clog2(VOICE_LIMIT + 1);
   localparam int SUM_W = VAL_W + NV_W;
   localparam int DCW   = $clog2(SUM_W);
   localparam int D_MAX = (DELAY_DEPTH - 2) * 256;
   localparam int D_WRAP = DELAY_DEPTH * 256;

   // Configuration registers.
   logic [15:0] lfo_step_ff;
   logic [16:0] mod_depth_ff, wet_mix_ff;
   logic [3:0]  voice_count_ff;
   logic [19:0] base_delay_ff, mod_range_ff, voice_spread_ff;

   state_type state_ff, state_in;
   logic      reseed, accept, cordic_start, ram_ready, last_voice;

   logic signed [OSC_W-1:0] sin_ff [VOICE_LIMIT];
   logic signed [OSC_W-1:0] cos_ff [VOICE_LIMIT];

   logic [VIW-1:0]  v_ff;
   logic [31:0]     t_ff;
   logic [4:0]      r_ff;
   logic [5:0]      r_sum;
   logic [NV_W-1:0] nv;
   logic [16:0]     depth_eff, mix_eff;

   logic signed [SAMPLE_BITS-1:0] x_ff, p0_ff, p1_ff, p2_ff, ram_q;
   logic signed [VAL_W-1:0]       a2, b2, c2, b2_ff, c2_ff, hv, wet;
   logic signed [SUM_W-1:0]       sum_ff, wet_full;
   logic [SUM_W-1:0]              dq_ff;
   logic [NV_W-1:0]               rem_ff;
   logic [NV_W:0]                 trial;
   logic                          neg_ff;
   logic [DCW-1:0]                div_cnt_ff;
   logic signed [D_W-1:0]         d_ff, d_raw, mod_d, pos_raw;
   logic [AW-1:0]                 ri_ff, ri_m1, ri_p1, ri_p2, wp_ff, raddr;
   logic [AW:0]                   ri2;
   logic [7:0]                    f_ff;
   logic signed [ACC_W-1:0]       acc_ff, o_full;
   logic signed [SAMPLE_BITS-1:0] o_ff, rsp_data_ff;
   logic                          rsp_valid_ff;

   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic signed [MP_W-1:0] mul_p, e_full, mod_full, h_full;
   logic signed [OSC_SUM_W-1:0] e_rnd;
   logic signed [OSC_W-1:0]     s_new, c_new;
   cordic_res_type              cordic_res;

   // Shared units.
   mvc_mult u_mult (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   mvc_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .turn  (t_ff),
      .res   (cordic_res)
   );

   mvc_delay_ram #(.DEPTH(DELAY_DEPTH)) u_ram (
      .clock (clock),
      .reset (reset),
      .we    (accept),
      .waddr (wp_ff),
      .wdata ($signed(req_tdata)),
      .raddr (raddr),
      .rdata (ram_q),
      .ready (ram_ready)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         lfo_step_ff     <= 16'd1098;
         mod_depth_ff    <= 17'd32768;
         wet_mix_ff      <= 17'd32768;
         voice_count_ff  <= 4'd2;
         base_delay_ff   <= 20'd245760;
         mod_range_ff    <= 20'd61440;
         voice_spread_ff <= 20'd0;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_LFO_STEP:     lfo_step_ff     <= csr_wdata[15:0];
            REG_MOD_DEPTH:    mod_depth_ff    <= csr_wdata[16:0];
            REG_WET_MIX:      wet_mix_ff      <= csr_wdata[16:0];
            REG_VOICE_COUNT:  voice_count_ff  <= csr_wdata[3:0];
            REG_BASE_DELAY:   base_delay_ff   <= csr_wdata[19:0];
            REG_MOD_RANGE:    mod_range_ff    <= csr_wdata[19:0];
            REG_VOICE_SPREAD: voice_spread_ff <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   assign reseed = csr_we && (csr_index == REG_VOICE_COUNT);

   // Effective voice count, depth and mix.
   always_comb begin
      if (voice_count_ff < 4'd2) begin
         nv = NV_W'(2);
      end else if (int'(voice_count_ff) > VOICE_LIMIT) begin
         nv = NV_W'(VOICE_LIMIT);
      end else begin
         nv = NV_W'(voice_count_ff);
      end
      depth_eff = (mod_depth_ff > 17'd65536) ? 17'd65536 : mod_depth_ff;
      mix_eff   = (wet_mix_ff > 17'd65536) ? 17'd65536 : wet_mix_ff;
   end

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE) && ram_ready;
   assign last_voice = (NV_W'(v_ff) == nv - NV_W'(1));

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SEED_GO;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in     = state_ff;
      cordic_start = 1'b0;
      case (state_ff)
         ST_SEED_GO: begin
            cordic_start = 1'b1;
            state_in     = ST_SEED_WAIT;
         end
         ST_SEED_WAIT: begin
            if (cordic_res.done) begin
               state_in = (v_ff == VIW'(VOICE_LIMIT - 1)) ? ST_IDLE : ST_SEED_GO;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EPSC;
            end
         end
         ST_EPSC:     state_in = ST_SIN;
         ST_SIN:      state_in = ST_COS;
         ST_COS:      state_in = ST_RD;
         ST_RD:       state_in = ST_MOD;
         ST_MOD:      state_in = ST_POS;
         ST_POS:      state_in = ST_TAP0;
         ST_TAP0:     state_in = ST_TAP1;
         ST_TAP1:     state_in = ST_TAP2;
         ST_TAP2:     state_in = ST_TAP3;
         ST_TAP3:     state_in = ST_CUBE;
         ST_CUBE:     state_in = ST_H1;
         ST_H1:       state_in = ST_H2;
         ST_H2:       state_in = ST_H3;
         ST_H3:       state_in = last_voice ? ST_DIV_LOAD : ST_EPSC;
         ST_DIV_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (div_cnt_ff == DCW'(SUM_W - 1)) begin
               state_in = ST_OUT1;
            end
         end
         ST_OUT1:     state_in = ST_OUT2;
         ST_OUT2:     state_in = ST_OUT3;
         ST_OUT3:     state_in = ST_EMIT;
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
      if (reseed) begin
         state_in = ST_SEED_GO;
      end
   end

   // Oscillator update arithmetic.
   always_comb begin
      e_full = (mul_p + MP_W'(64'sd8388608)) >>> 24;
      e_rnd  = e_full[OSC_SUM_W-1:0];
      s_new  = sat_osc(OSC_SUM_W'(sin_ff[v_ff]) + e_rnd);
      c_new  = sat_osc(OSC_SUM_W'(cos_ff[v_ff]) - e_rnd);
   end

   // Voice delay and read position.
   always_comb begin
      mod_full = (mul_p + MP_W'(64'sd2147483648)) >>> 32;
      mod_d    = mod_full[D_W-1:0];
      if (v_ff[0]) begin
         d_raw = $signed(D_W'(base_delay_ff)) - $signed(D_W'(voice_spread_ff)) + mod_d;
      end else begin
         d_raw = $signed(D_W'(base_delay_ff)) + $signed(D_W'(voice_spread_ff)) + mod_d;
      end
      pos_raw = $signed(D_W'({wp_ff, 8'b0})) - d_ff;
      if (pos_raw < 0) begin
         pos_raw = pos_raw + D_W'(D_WRAP);
      end
   end

   // Tap addresses around the read point.
   always_comb begin
      ri_m1 = (ri_ff == '0) ? AW'(DELAY_DEPTH - 1) : ri_ff - AW'(1);
      ri_p1 = (ri_ff == AW'(DELAY_DEPTH - 1)) ? '0 : ri_ff + AW'(1);
      ri2   = {1'b0, ri_ff} + (AW+1)'(2);
      ri_p2 = (ri2 >= (AW+1)'(DELAY_DEPTH)) ? AW'(ri2 - (AW+1)'(DELAY_DEPTH)) : ri2[AW-1:0];
      case (state_ff)
         ST_TAP0: raddr = ri_m1;
         ST_TAP2: raddr = ri_p1;
         ST_TAP3: raddr = ri_p2;
         default: raddr = ri_ff;
      endcase
   end

   // Hermite coefficients, tap value, the averaged wet value, the divider trial and the output mix.
   always_comb begin
      a2 = VAL_W'(-VAL_W'(p0_ff) + 3 * VAL_W'(p1_ff) - 3 * VAL_W'(p2_ff) + VAL_W'(ram_q));
      b2 = VAL_W'(2 * VAL_W'(p0_ff) - 5 * VAL_W'(p1_ff) + 4 * VAL_W'(p2_ff) - VAL_W'(ram_q));
      c2 = VAL_W'(p2_ff) - VAL_W'(p0_ff);
      h_full   = (mul_p + MP_W'(64'sd16777216)) >>> 25;
      hv       = VAL_W'(p1_ff) + h_full[VAL_W-1:0];
      wet_full = neg_ff ? -$signed(dq_ff) : $signed(dq_ff);
      wet      = wet_full[VAL_W-1:0];
      trial    = {rem_ff, dq_ff[SUM_W-1]};
      o_full   = (acc_ff + $signed(mul_p[ACC_W-1:0]) + ACC_W'(32768)) >>> 16;
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (state_ff)
         ST_EPSC: begin
            mul_a = MA_W'(lfo_step_ff);
            mul_b = MB_W'(cos_ff[v_ff]);
         end
         ST_SIN: begin
            mul_a = MA_W'(lfo_step_ff);
            mul_b = MB_W'(s_new);
         end
         ST_COS: begin
            mul_a = MA_W'(mod_range_ff);
            mul_b = MB_W'(depth_eff);
         end
         ST_RD: begin
            mul_a = MA_W'(mul_p[36:0]);
            mul_b = MB_W'(sin_ff[v_ff]);
         end
         ST_CUBE: begin
            mul_a = MA_W'(a2);
            mul_b = MB_W'(f_ff);
         end
         ST_H1: begin
            mul_a = mul_p[MA_W-1:0] + (MA_W'(b2_ff) <<< 8);
            mul_b = MB_W'(f_ff);
         end
         ST_H2: begin
            mul_a = mul_p[MA_W-1:0] + (MA_W'(c2_ff) <<< 16);
            mul_b = MB_W'(f_ff);
         end
         ST_OUT1: begin
            mul_a = MA_W'(x_ff);
            mul_b = MB_W'(18'd65536 - 18'(mix_eff));
         end
         ST_OUT2: begin
            mul_a = MA_W'(wet);
            mul_b = MB_W'(mix_eff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign r_sum = 6'(r_ff) + 6'(phase_rem(5'(nv)));

   // Control registers: voice index, phase accumulator, write pointer, result valid.
   always_ff @(posedge clock) begin
      if (reset || reseed) begin
         v_ff <= '0;
         t_ff <= '0;
         r_ff <= '0;
      end else begin
         case (state_ff)
            ST_SEED_WAIT: begin
               if (cordic_res.done) begin
                  v_ff <= v_ff + VIW'(1);
                  if (r_sum >= 6'(nv)) begin
                     t_ff <= t_ff + phase_quot(5'(nv)) + 32'd1;
                     r_ff <= 5'(r_sum - 6'(nv));
                  end else begin
                     t_ff <= t_ff + phase_quot(5'(nv));
                     r_ff <= r_sum[4:0];
                  end
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  v_ff <= '0;
               end
            end
            ST_H3: begin
               if (!last_voice) begin
                  v_ff <= v_ff + VIW'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready)) begin
         wp_ff        <= (wp_ff == AW'(DELAY_DEPTH - 1)) ? '0 : wp_ff + AW'(1);
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Oscillator state: seeding and per-sample update.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_SEED_WAIT) && cordic_res.done) begin
         sin_ff[v_ff] <= cordic_res.sin_val;
         cos_ff[v_ff] <= cordic_res.cos_val;
      end else if (state_ff == ST_SIN) begin
         sin_ff[v_ff] <= s_new;
      end else if (state_ff == ST_COS) begin
         cos_ff[v_ff] <= c_new;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            x_ff   <= $signed(req_tdata);
            sum_ff <= '0;
         end
         ST_MOD: begin
            if (d_raw < D_W'(256)) begin
               d_ff <= D_W'(256);
            end else if (d_raw > D_W'(D_MAX)) begin
               d_ff <= D_W'(D_MAX);
            end else begin
               d_ff <= d_raw;
            end
         end
         ST_POS: begin
            ri_ff <= pos_raw[AW+7:8];
            f_ff  <= pos_raw[7:0];
         end
         ST_TAP1: p0_ff <= ram_q;
         ST_TAP2: p1_ff <= ram_q;
         ST_TAP3: p2_ff <= ram_q;
         ST_CUBE: begin
            b2_ff <= b2;
            c2_ff <= c2;
         end
         ST_H3: sum_ff <= sum_ff + SUM_W'(hv);
         ST_DIV_LOAD: begin
            neg_ff     <= sum_ff[SUM_W-1];
            dq_ff      <= sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
            rem_ff     <= '0;
            div_cnt_ff <= '0;
         end
         ST_DIV: begin
            div_cnt_ff <= div_cnt_ff + DCW'(1);
            if (trial >= {1'b0, nv}) begin
               rem_ff <= NV_W'(trial - {1'b0, nv});
               dq_ff  <= {dq_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial[NV_W-1:0];
               dq_ff  <= {dq_ff[SUM_W-2:0], 1'b0};
            end
         end
         ST_OUT2: acc_ff <= mul_p[ACC_W-1:0];
         ST_OUT3: begin
            if (o_full > ACC_W'(32767)) begin
               o_ff <= SAMPLE_BITS'(32767);
            end else if (o_full < -ACC_W'(32768)) begin
               o_ff <= -SAMPLE_BITS'(32768);
            end else begin
               o_ff <= o_full[SAMPLE_BITS-1:0];
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_ff <= o_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/mvc_checker.sv
module mvc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mvc_pkg::SAMPLE_BITS-1:0] rsp_tdata
);
   import mvc_pkg::*;

   // A stalled result stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A stalled result keeps its data.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result data changed while stalled");

   // An accepted sample keeps the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after a transaction");

   // Reset keeps the input closed while seeding and clearing start.
   a_closed_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("input ready right after reset");

endmodule

bind multivoice_chorus mvc_checker u_mvc_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import mvc_pkg::*;

   localparam int DEPTH       = 4096;
   localparam int VOICES      = 8;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 120;
   localparam logic [CSR_IDX_W-1:0] UNUSED_INDEX = 3'd7;
   localparam longint OSC_TOP = 131071;
   localparam longint OSC_BOTTOM = -131072;
   localparam longint ATAN_TURN [20] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304
   };

   // Chorus predictor and the store of expected output samples.
   class chorus_scoreboard;
      logic [15:0] lfo_step;
      logic [16:0] mod_depth;
      logic [16:0] wet_mix;
      logic [3:0]  voice_count;
      logic [19:0] base_delay;
      logic [19:0] mod_range;
      logic [19:0] voice_spread;
      logic signed [15:0] history [DEPTH];
      int          head;
      longint      lfo_sin [VOICES];
      longint      lfo_cos [VOICES];
      logic [15:0] expected_out [$];
      int          errors;
      int          samples_in;
      int          samples_out;

      function void restart();
         lfo_step = 1098; mod_depth = 32768; wet_mix = 32768; voice_count = 2;
         base_delay = 245760; mod_range = 61440; voice_spread = 0;
         foreach (history[i]) history[i] = '0;
         head = 0;
         reseed();
      endfunction

      function int voices_used();
         int n;
         n = voice_count;
         if (n < 2) n = 2;
         if (n > VOICES) n = VOICES;
         return n;
      endfunction

      // Integer CORDIC rotation of a 32-bit turn fraction, rounded to Q2.16.
      function void turn_to_phasor(input logic [31:0] turn, output longint co,
                                   output longint si);
         longint x, y, z, dx, dy, c, s;
         x = 652032874; y = 0; z = turn[29:0];
         for (int k = 0; k < 20; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
               x -= dx; y += dy; z -= ATAN_TURN[k];
            end else begin
               x += dx; y -= dy; z += ATAN_TURN[k];
            end
         end
         c = (x + 8192) >>> 14;
         s = (y + 8192) >>> 14;
         case (turn[31:30])
            2'd0: begin co = c;  si = s;  end
            2'd1: begin co = -s; si = c;  end
            2'd2: begin co = -c; si = -s; end
            default: begin co = s; si = -c; end
         endcase
      endfunction

      function void reseed();
         longint unsigned t;
         for (int i = 0; i < VOICES; i++) begin
            t = (longint'(i) << 32) / voices_used();
            turn_to_phasor(t[31:0], lfo_cos[i], lfo_sin[i]);
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] value);
         case (index)
            REG_LFO_STEP:     lfo_step = value[15:0];
            REG_MOD_DEPTH:    mod_depth = value[16:0];
            REG_WET_MIX:      wet_mix = value[16:0];
            REG_VOICE_COUNT: begin
               voice_count = value[3:0];
               reseed();
            end
            REG_BASE_DELAY:   base_delay = value;
            REG_MOD_RANGE:    mod_range = value;
            REG_VOICE_SPREAD: voice_spread = value;
            default: ;
         endcase
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      // Note an accepted input transaction and work out its output sample.
      function void note_input(logic [15:0] raw);
         longint x, depth, mix, eps, sum, wet, o, s, c, d, pos, f;
         longint p0, p1, p2, p3, a2, b2, c2, num;
         int nv, ri;
         x = longint'($signed(raw));
         depth = mod_depth > 65536 ? 65536 : mod_depth;
         mix = wet_mix > 65536 ? 65536 : wet_mix;
         eps = lfo_step;
         sum = 0;
         nv = voices_used();
         history[head] = raw;
         for (int v = 0; v < nv; v++) begin
            s = clip(lfo_sin[v] + ((eps * lfo_cos[v] + (1 << 23)) >>> 24), OSC_BOTTOM, OSC_TOP);
            c = clip(lfo_cos[v] - ((eps * s + (1 << 23)) >>> 24), OSC_BOTTOM, OSC_TOP);
            lfo_sin[v] = s;
            lfo_cos[v] = c;
            d = longint'(base_delay) + ((v % 2) ? -longint'(voice_spread) : longint'(voice_spread));
            d += (s * longint'(mod_range) * depth + (longint'(1) << 31)) >>> 32;
            d = clip(d, 256, (DEPTH - 2) * 256);
            pos = longint'(head) * 256 - d;
            if (pos < 0) pos += DEPTH * 256;
            ri = (pos >> 8) % DEPTH;
            f = pos & 255;
            p0 = history[(ri + DEPTH - 1) % DEPTH];
            p1 = history[ri];
            p2 = history[(ri + 1) % DEPTH];
            p3 = history[(ri + 2) % DEPTH];
            a2 = -p0 + 3 * p1 - 3 * p2 + p3;
            b2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
            c2 = p2 - p0;
            num = ((a2 * f + b2 * 256) * f + c2 * 65536) * f;
            sum += p1 + ((num + (1 << 24)) >>> 25);
         end
         wet = sum / nv;
         o = (x * (65536 - mix) + wet * mix + 32768) >>> 16;
         o = clip(o, -32768, 32767);
         expected_out.push_back(o[15:0]);
         head = (head + 1) % DEPTH;
         samples_in++;
      endfunction

      // Compare an output transaction with the oldest expectation.
      function void check_output(logic [15:0] actual);
         logic [15:0] want;
         samples_out++;
         if (expected_out.size() == 0) begin
            $error("sample_out: no expectation waiting, actual %0d", $signed(actual));
            errors++;
         end else begin
            want = expected_out.pop_front();
            if (want !== actual) begin
               $error("sample_out: expected %0d, actual %0d", $signed(want), $signed(actual));
               errors++;
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   chorus_scoreboard board = new();
   bit calm = 1'b0;
   int hold_left = 0;
   int cycles = 0;

   multivoice_chorus i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [15:0] sample_in
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [15:0] sample_out
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Output side: random stalls, mostly short, some long, none started while calm.
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (calm || r < 70) begin
         rsp_tready <= 1'b1;
      end else if (r < 95) begin
         hold_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         hold_left <= $urandom_range(10, 200);
         rsp_tready <= 1'b0;
      end
   end

   // Output transaction monitor.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_output(rsp_tdata);
   end

   // Send one sample, after a random gap unless the phase is calm.
   task automatic send_sample(logic [15:0] value);
      int r, gap;
      r = $urandom_range(0, 99);
      gap = (calm || r < 50) ? 0 : (r < 90 ? $urandom_range(1, 3) : $urandom_range(20, 200));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
      board.note_input(value);
   endtask

   // Let the block drain, then write one register.
   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] value);
      req_tvalid <= 1'b0;
      while (board.expected_out.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.write_reg(index, value);
   endtask

   function automatic logic [CFG_W-1:0] pick(int lo, int hi, int usual_hi);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return CFG_W'(lo);
      if (r == 1) return CFG_W'(hi);
      if (r == 2) return CFG_W'($urandom_range(0, 20'hFFFFF));
      return CFG_W'($urandom_range(lo, usual_hi));
   endfunction

   // Random sample: mostly full range, sometimes extremes or small values.
   function automatic logic [15:0] any_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h7FFF;
      if (r == 1) return 16'h8000;
      if (r == 2) return 16'($signed($urandom_range(0, 511)) - 256);
      return 16'($urandom);
   endfunction

   initial begin
      board.restart();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes at the reset settings.
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'h0001);
      for (int i = 0; i < 5; i++) send_sample(i % 2 ? 16'h8000 : 16'h7FFF);

      // Directed: depth and mix above one, fast oscillator, voice count below range,
      // shortest delay, widest modulation range and spread, and a write to an unused index.
      write_reg(REG_MOD_DEPTH, 20'h1FFFF);
      write_reg(REG_WET_MIX, 20'h1FFFF);
      write_reg(REG_LFO_STEP, 20'hFFFF);
      write_reg(REG_VOICE_COUNT, 20'd0);
      write_reg(REG_BASE_DELAY, 20'd0);
      write_reg(REG_MOD_RANGE, 20'hFFFFF);
      write_reg(REG_VOICE_SPREAD, 20'hFFFFF);
      write_reg(UNUSED_INDEX, 20'hABCDE);
      for (int i = 0; i < 6; i++) send_sample(i % 2 ? 16'h8000 : 16'h7FFF);

      // Directed: voice count above range, longest delay, fully dry, no modulation depth.
      write_reg(REG_VOICE_COUNT, 20'd15);
      write_reg(REG_BASE_DELAY, 20'hFFFFF);
      write_reg(REG_WET_MIX, 20'd0);
      write_reg(REG_MOD_DEPTH, 20'd0);
      for (int i = 0; i < 6; i++) send_sample(any_sample());

      // Random phases, each with fresh settings.
      for (int p = 0; p < PHASES; p++) begin
         write_reg(REG_LFO_STEP, pick(0, 65535, 4000));
         write_reg(REG_MOD_DEPTH, pick(0, 131071, 65536));
         write_reg(REG_WET_MIX, pick(0, 131071, 65536));
         if (p == PHASES - 1) write_reg(REG_VOICE_COUNT, 20'd8);
         else if ($urandom_range(0, 1)) write_reg(REG_VOICE_COUNT, CFG_W'($urandom_range(0, 15)));
         write_reg(REG_BASE_DELAY, pick(0, 1048575, 4094 * 256));
         write_reg(REG_MOD_RANGE, pick(0, 1048575, 256 * 256));
         write_reg(REG_VOICE_SPREAD, pick(0, 1048575, 64 * 256));
         if ($urandom_range(0, 3) == 0) write_reg(UNUSED_INDEX, CFG_W'($urandom));
         calm = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < PHASE_ITEMS; i++) send_sample(any_sample());
      end
      req_tvalid <= 1'b0;
      calm = 1'b0;

      while (board.expected_out.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Sent %0d samples and checked %0d outputs over %0d settings phases,",
               board.samples_in, board.samples_out, PHASES + 3);
      $display("with clamped delays, saturating oscillators and out-of-range registers.");
      if (board.errors == 0 && board.expected_out.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/mvc_pkg.sv
rtl/mvc_mult.sv
rtl/mvc_delay_ram.sv
rtl/mvc_cordic.sv
rtl/multivoice_chorus.sv
rtl/mvc_checker.sv
bench/testbench.sv
